// File: design/drive_command_decoder_core_assert.svh
// Assertion macros for the drive command decoder.
// Taken in by the top level; needs nothing else.
`ifndef DRIVE_COMMAND_DECODER_CORE_ASSERT_SVH
`define DRIVE_COMMAND_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `DCD_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define DCD_ASSERT(label, clk, rst_n, prop, msg)
`define DCD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: design/dcd_pkg.sv
// Shared types and constants of the drive command decoder.
// No dependencies.
package dcd_pkg;

  typedef enum logic [3:0] {
    MOT_STOP = 4'd0,
    MOT_F    = 4'd1,
    MOT_B    = 4'd2,
    MOT_L    = 4'd3,
    MOT_R    = 4'd4,
    MOT_G    = 4'd5,
    MOT_I    = 4'd6,
    MOT_H    = 4'd7,
    MOT_J    = 4'd8
  } motion_e;

  // ASCII command bytes
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_4     = 8'h34;
  localparam logic [7:0] CHR_6     = 8'h36;
  localparam logic [7:0] CHR_7     = 8'h37;
  localparam logic [7:0] CHR_8     = 8'h38;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_F     = 8'h46;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_L     = 8'h4C;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_G     = 8'h47;
  localparam logic [7:0] CHR_I     = 8'h49;
  localparam logic [7:0] CHR_H     = 8'h48;
  localparam logic [7:0] CHR_J     = 8'h4A;
  localparam logic [7:0] CHR_W_UP  = 8'h57;
  localparam logic [7:0] CHR_W_LO  = 8'h77;
  localparam logic [7:0] CHR_U_UP  = 8'h55;
  localparam logic [7:0] CHR_U_LO  = 8'h75;
  localparam logic [7:0] CHR_V_UP  = 8'h56;
  localparam logic [7:0] CHR_V_LO  = 8'h76;

  localparam logic [7:0] SPEED_0 = 8'd100;
  localparam logic [7:0] SPEED_4 = 8'd140;
  localparam logic [7:0] SPEED_6 = 8'd180;
  localparam logic [7:0] SPEED_7 = 8'd200;
  localparam logic [7:0] SPEED_8 = 8'd240;
  localparam logic [7:0] SPEED_9 = 8'd255;

  localparam logic [7:0]  SPEED_RESET   = 8'd255;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]  speed;
    motion_e     motion;
    logic [15:0] idle;
    logic        front;
    logic        rear;
    logic        horn;
  } state_t;

  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic       a_in1;
    logic       a_in2;
    logic       b_in1;
    logic       b_in2;
    logic       front_lights;
    logic       rear_lights;
    logic       horn_on;
  } result_t;

endpackage

// File: design/dcd_if.sv
// Handshake channels of the drive command decoder: request, result, config.
// No dependencies.
interface dcd_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] command_byte;
  modport source (output valid, opcode, command_byte, input ready);
  modport sink (input valid, opcode, command_byte, output ready);
endinterface

interface dcd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_a;
  logic [7:0] duty_b;
  logic       a_in1;
  logic       a_in2;
  logic       b_in1;
  logic       b_in2;
  logic       front_lights;
  logic       rear_lights;
  logic       horn_on;
  modport source (output valid, duty_a, duty_b, a_in1, a_in2, b_in1, b_in2,
                  front_lights, rear_lights, horn_on, input ready);
  modport sink (input valid, duty_a, duty_b, a_in1, a_in2, b_in1, b_in2,
                front_lights, rear_lights, horn_on, output ready);
endinterface

interface dcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/dcd_decode.sv
// Command decode: next state and drive outputs for one request.
// Uses dcd_pkg.
module dcd_decode (
  input  dcd_pkg::state_t  state_i,
  input  logic             opcode_i,
  input  logic [7:0]       command_byte_i,
  input  logic [15:0]      timeout_i,
  output dcd_pkg::state_t  state_o,
  output dcd_pkg::result_t result_o
);

  dcd_pkg::state_t  nxt;
  dcd_pkg::result_t res;
  logic [7:0]       full;
  logic [7:0]       half;

  always_comb begin
    nxt = state_i;
    if (opcode_i == dcd_pkg::OP_BYTE) begin
      nxt.idle = '0;
      case (command_byte_i)
        dcd_pkg::CHR_0:    nxt.speed  = dcd_pkg::SPEED_0;
        dcd_pkg::CHR_4:    nxt.speed  = dcd_pkg::SPEED_4;
        dcd_pkg::CHR_6:    nxt.speed  = dcd_pkg::SPEED_6;
        dcd_pkg::CHR_7:    nxt.speed  = dcd_pkg::SPEED_7;
        dcd_pkg::CHR_8:    nxt.speed  = dcd_pkg::SPEED_8;
        dcd_pkg::CHR_9:    nxt.speed  = dcd_pkg::SPEED_9;
        dcd_pkg::CHR_S:    nxt.motion = dcd_pkg::MOT_STOP;
        dcd_pkg::CHR_F:    nxt.motion = dcd_pkg::MOT_F;
        dcd_pkg::CHR_B:    nxt.motion = dcd_pkg::MOT_B;
        dcd_pkg::CHR_L:    nxt.motion = dcd_pkg::MOT_L;
        dcd_pkg::CHR_R:    nxt.motion = dcd_pkg::MOT_R;
        dcd_pkg::CHR_G:    nxt.motion = dcd_pkg::MOT_G;
        dcd_pkg::CHR_I:    nxt.motion = dcd_pkg::MOT_I;
        dcd_pkg::CHR_H:    nxt.motion = dcd_pkg::MOT_H;
        dcd_pkg::CHR_J:    nxt.motion = dcd_pkg::MOT_J;
        dcd_pkg::CHR_W_UP: nxt.front  = 1'b1;
        dcd_pkg::CHR_W_LO: nxt.front  = 1'b0;
        dcd_pkg::CHR_U_UP: nxt.rear   = 1'b1;
        dcd_pkg::CHR_U_LO: nxt.rear   = 1'b0;
        dcd_pkg::CHR_V_UP: nxt.horn   = 1'b1;
        dcd_pkg::CHR_V_LO: nxt.horn   = 1'b0;
        default: ;
      endcase
    end else if (state_i.idle != dcd_pkg::IDLE_MAX) begin
      nxt.idle = state_i.idle + 16'd1;
    end
    // failsafe: too long without a byte
    if (nxt.idle > timeout_i) begin
      nxt.motion = dcd_pkg::MOT_STOP;
    end
  end

  assign full = nxt.speed;
  assign half = {1'b0, nxt.speed[7:1]};

  always_comb begin
    res              = '0;
    res.front_lights = nxt.front;
    res.rear_lights  = nxt.rear;
    res.horn_on      = nxt.horn;
    case (nxt.motion)
      dcd_pkg::MOT_F: begin
        res.duty_a = full; res.duty_b = full; res.a_in2 = 1'b1; res.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_B: begin
        res.duty_a = full; res.duty_b = full; res.a_in1 = 1'b1; res.b_in2 = 1'b1;
      end
      dcd_pkg::MOT_L: begin
        res.duty_a = full; res.duty_b = full; res.a_in2 = 1'b1; res.b_in2 = 1'b1;
      end
      dcd_pkg::MOT_R: begin
        res.duty_a = full; res.duty_b = full; res.a_in1 = 1'b1; res.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_G: begin
        res.duty_a = half; res.duty_b = full; res.a_in2 = 1'b1; res.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_I: begin
        res.duty_a = full; res.duty_b = half; res.a_in2 = 1'b1; res.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_H: begin
        res.duty_a = half; res.duty_b = full; res.a_in1 = 1'b1; res.b_in2 = 1'b1;
      end
      dcd_pkg::MOT_J: begin
        res.duty_a = full; res.duty_b = half; res.a_in1 = 1'b1; res.b_in2 = 1'b1;
      end
      default: ;
    endcase
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// File: design/dcd_out_buf.sv
// Two-entry result buffer that decouples the request and result sides.
// Uses dcd_pkg.
module dcd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dcd_pkg::result_t data_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dcd_pkg::result_t data_o
);

  dcd_pkg::result_t entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

// File: design/drive_command_decoder_core.sv
// Drive command decoder top level: state registers, decode, result buffer.
// Uses dcd_pkg, dcd_if.sv, dcd_decode, dcd_out_buf and the assertion header.
//
// Takes one request per clock: a received command byte (opcode 0) or a
// millisecond tick (opcode 1), and gives exactly one result per request,
// held in the result buffer. Decode is a single pass of logic from the
// state registers into a two-entry result buffer, so requests keep flowing
// while a result waits; req_i.ready drops only when both buffer entries are
// held. The failsafe timeout is written through cfg_i (always ready) and
// resets to 3000 ticks; write it only while no request is in flight.
`include "drive_command_decoder_core_assert.svh"
module drive_command_decoder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dcd_req_if.sink   req_i,
  dcd_rsp_if.source rsp_o,
  dcd_cfg_if.sink   cfg_i
);

  dcd_pkg::state_t  state_q, state_d;
  dcd_pkg::result_t result_d, result_buf;
  logic [15:0]      timeout_q;
  logic             req_accept;
  logic             rsp_pop;
  logic             buf_space;
  logic             buf_valid;

  assign req_accept = req_i.valid && buf_space;
  assign rsp_pop    = buf_valid && rsp_o.ready;
  assign req_i.ready = buf_space;
  assign cfg_i.ready = 1'b1;

  dcd_decode u_decode (
    .state_i        (state_q),
    .opcode_i       (req_i.opcode),
    .command_byte_i (req_i.command_byte),
    .timeout_i      (timeout_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.speed  <= dcd_pkg::SPEED_RESET;
      state_q.motion <= dcd_pkg::MOT_STOP;
      state_q.idle   <= '0;
      state_q.front  <= 1'b0;
      state_q.rear   <= 1'b0;
      state_q.horn   <= 1'b0;
      timeout_q      <= dcd_pkg::TIMEOUT_RESET;
    end else begin
      if (req_accept) begin
        state_q <= state_d;
      end
      if (cfg_i.valid) begin
        timeout_q <= cfg_i.data;
      end
    end
  end

  dcd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_accept),
    .data_i  (result_d),
    .space_o (buf_space),
    .pop_i   (rsp_pop),
    .valid_o (buf_valid),
    .data_o  (result_buf)
  );

  assign rsp_o.valid        = buf_valid;
  assign rsp_o.duty_a       = result_buf.duty_a;
  assign rsp_o.duty_b       = result_buf.duty_b;
  assign rsp_o.a_in1        = result_buf.a_in1;
  assign rsp_o.a_in2        = result_buf.a_in2;
  assign rsp_o.b_in1        = result_buf.b_in1;
  assign rsp_o.b_in2        = result_buf.b_in2;
  assign rsp_o.front_lights = result_buf.front_lights;
  assign rsp_o.rear_lights  = result_buf.rear_lights;
  assign rsp_o.horn_on      = result_buf.horn_on;

  `DCD_ASSERT(a_result_follows, clk_i, rst_ni, req_accept |=> buf_valid, "no result after request")
  `DCD_ASSERT_NEVER(a_stop_no_duty, clk_i, rst_ni, buf_valid && !result_buf.a_in1 && !result_buf.a_in2 && !result_buf.b_in1 && !result_buf.b_in2 && (result_buf.duty_a != 8'd0 || result_buf.duty_b != 8'd0), "duty while stopped")
  `DCD_ASSERT(a_idle_saturates, clk_i, rst_ni, (req_accept && state_q.idle == dcd_pkg::IDLE_MAX && req_i.opcode == dcd_pkg::OP_TICK) |=> (state_q.idle == dcd_pkg::IDLE_MAX), "idle counter wrapped")

endmodule

// File: tb/sv/tb_drive_command_decoder_core.sv
`timescale 1ns / 100ps
// Self-checking bench for drive_command_decoder_core: directed and random
// command bytes and ticks, with a local predictor. Needs dcd_pkg and dcd_if.sv.
module tb_drive_command_decoder_core;

  typedef struct {
    logic        op;
    logic [7:0]  cmd;
    int unsigned gap;
  } drive_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcd_req_if req_if ();
  dcd_rsp_if rsp_if ();
  dcd_cfg_if cfg_if ();

  drive_command_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // speeds 0..5, motions 6..14, lights and horn 15..20
  logic [7:0] known_cmds [0:20] = '{
    dcd_pkg::CHR_0, dcd_pkg::CHR_4, dcd_pkg::CHR_6, dcd_pkg::CHR_7,
    dcd_pkg::CHR_8, dcd_pkg::CHR_9,
    dcd_pkg::CHR_S, dcd_pkg::CHR_F, dcd_pkg::CHR_B, dcd_pkg::CHR_L,
    dcd_pkg::CHR_R, dcd_pkg::CHR_G, dcd_pkg::CHR_I, dcd_pkg::CHR_H,
    dcd_pkg::CHR_J,
    dcd_pkg::CHR_W_UP, dcd_pkg::CHR_W_LO, dcd_pkg::CHR_U_UP,
    dcd_pkg::CHR_U_LO, dcd_pkg::CHR_V_UP, dcd_pkg::CHR_V_LO
  };

  drive_req_t       cmd_queue [$];
  dcd_pkg::result_t expected_drive_q [$];
  drive_req_t       next_req;
  int unsigned      fail_count = 0;
  int unsigned      rsp_wait;
  bit               idle_off = 1'b0;
  bit               stall_go = 1'b0;
  logic             rsp_hold = 1'b0;

  // predictor state
  logic [7:0]       m_speed;
  dcd_pkg::motion_e m_motion;
  logic [15:0]      m_idle;
  logic             m_front;
  logic             m_rear;
  logic             m_horn;
  logic [15:0]      m_timeout;

  function automatic int unsigned draw_gap();
    if (idle_off || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic predict_drive_outputs(input logic op, input logic [7:0] cb);
    dcd_pkg::result_t r;
    logic [7:0]       full;
    logic [7:0]       half;
    if (op == dcd_pkg::OP_BYTE) begin
      case (cb)
        dcd_pkg::CHR_0:    m_speed = dcd_pkg::SPEED_0;
        dcd_pkg::CHR_4:    m_speed = dcd_pkg::SPEED_4;
        dcd_pkg::CHR_6:    m_speed = dcd_pkg::SPEED_6;
        dcd_pkg::CHR_7:    m_speed = dcd_pkg::SPEED_7;
        dcd_pkg::CHR_8:    m_speed = dcd_pkg::SPEED_8;
        dcd_pkg::CHR_9:    m_speed = dcd_pkg::SPEED_9;
        dcd_pkg::CHR_S:    m_motion = dcd_pkg::MOT_STOP;
        dcd_pkg::CHR_F:    m_motion = dcd_pkg::MOT_F;
        dcd_pkg::CHR_B:    m_motion = dcd_pkg::MOT_B;
        dcd_pkg::CHR_L:    m_motion = dcd_pkg::MOT_L;
        dcd_pkg::CHR_R:    m_motion = dcd_pkg::MOT_R;
        dcd_pkg::CHR_G:    m_motion = dcd_pkg::MOT_G;
        dcd_pkg::CHR_I:    m_motion = dcd_pkg::MOT_I;
        dcd_pkg::CHR_H:    m_motion = dcd_pkg::MOT_H;
        dcd_pkg::CHR_J:    m_motion = dcd_pkg::MOT_J;
        dcd_pkg::CHR_W_UP: m_front = 1'b1;
        dcd_pkg::CHR_W_LO: m_front = 1'b0;
        dcd_pkg::CHR_U_UP: m_rear = 1'b1;
        dcd_pkg::CHR_U_LO: m_rear = 1'b0;
        dcd_pkg::CHR_V_UP: m_horn = 1'b1;
        dcd_pkg::CHR_V_LO: m_horn = 1'b0;
        default: ;
      endcase
      m_idle = '0;
    end else if (m_idle != dcd_pkg::IDLE_MAX) begin
      m_idle = m_idle + 16'd1;
    end
    if (m_idle > m_timeout) m_motion = dcd_pkg::MOT_STOP;
    full = m_speed;
    half = full >> 1;
    r = '0;
    case (m_motion)
      dcd_pkg::MOT_F: begin
        r.duty_a = full; r.duty_b = full; r.a_in2 = 1'b1; r.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_B: begin
        r.duty_a = full; r.duty_b = full; r.a_in1 = 1'b1; r.b_in2 = 1'b1;
      end
      dcd_pkg::MOT_L: begin
        r.duty_a = full; r.duty_b = full; r.a_in2 = 1'b1; r.b_in2 = 1'b1;
      end
      dcd_pkg::MOT_R: begin
        r.duty_a = full; r.duty_b = full; r.a_in1 = 1'b1; r.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_G: begin
        r.duty_a = half; r.duty_b = full; r.a_in2 = 1'b1; r.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_I: begin
        r.duty_a = full; r.duty_b = half; r.a_in2 = 1'b1; r.b_in1 = 1'b1;
      end
      dcd_pkg::MOT_H: begin
        r.duty_a = half; r.duty_b = full; r.a_in1 = 1'b1; r.b_in2 = 1'b1;
      end
      dcd_pkg::MOT_J: begin
        r.duty_a = full; r.duty_b = half; r.a_in1 = 1'b1; r.b_in2 = 1'b1;
      end
      default: ;
    endcase
    r.front_lights = m_front;
    r.rear_lights  = m_rear;
    r.horn_on      = m_horn;
    expected_drive_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.opcode       <= dcd_pkg::OP_BYTE;
      req_if.command_byte <= 8'd0;
    end else begin
      if (req_if.valid && req_if.ready)
        predict_drive_outputs(req_if.opcode, req_if.command_byte);
      if (!req_if.valid || req_if.ready) begin
        if (cmd_queue.size() != 0 && cmd_queue[0].gap != 0) begin
          cmd_queue[0].gap = cmd_queue[0].gap - 1;
          req_if.valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          next_req = cmd_queue.pop_front();
          req_if.valid        <= 1'b1;
          req_if.opcode       <= next_req.op;
          req_if.command_byte <= next_req.cmd;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t: result with nothing expected, duty_a %0d duty_b %0d",
                   $time, rsp_if.duty_a, rsp_if.duty_b);
          fail_count++;
        end else begin
          compare_field("duty_a", expected_drive_q[0].duty_a, rsp_if.duty_a);
          compare_field("duty_b", expected_drive_q[0].duty_b, rsp_if.duty_b);
          compare_field("a_in1", expected_drive_q[0].a_in1, rsp_if.a_in1);
          compare_field("a_in2", expected_drive_q[0].a_in2, rsp_if.a_in2);
          compare_field("b_in1", expected_drive_q[0].b_in1, rsp_if.b_in1);
          compare_field("b_in2", expected_drive_q[0].b_in2, rsp_if.b_in2);
          compare_field("front_lights", expected_drive_q[0].front_lights,
                        rsp_if.front_lights);
          compare_field("rear_lights", expected_drive_q[0].rear_lights,
                        rsp_if.rear_lights);
          compare_field("horn_on", expected_drive_q[0].horn_on, rsp_if.horn_on);
          void'(expected_drive_q.pop_front());
        end
        rsp_wait = draw_gap();
      end
      if (rsp_hold) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_wait != 0) begin
        rsp_wait = rsp_wait - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the result buffer fills and the request side stalls
  initial begin
    wait (stall_go);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (80) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  task automatic push_cmd(input logic op, input logic [7:0] cb);
    drive_req_t it;
    it.op  = op;
    it.cmd = cb;
    it.gap = draw_gap();
    cmd_queue.push_back(it);
  endtask

  // checked at the falling edge, once the driver's updates have settled
  task automatic drain();
    @(negedge clk_i);
    while (cmd_queue.size() != 0 || req_if.valid || expected_drive_q.size() != 0)
      @(negedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_failsafe_timeout(input logic [15:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    m_timeout = value;
  endtask

  // well-formed traffic mostly: motion then tick bursts near the timeout
  task automatic fill_random(input int unsigned n_items);
    int unsigned count;
    int unsigned burst;
    int unsigned kind;
    count = 0;
    while (count < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        push_cmd(dcd_pkg::OP_BYTE, known_cmds[5'($urandom_range(6, 14))]);
        burst = (m_timeout < 37) ? m_timeout + 3 : 40;
        burst = $urandom_range(0, burst);
        count += burst + 1;
        repeat (burst) push_cmd(dcd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      end else if (kind < 7) begin
        push_cmd(dcd_pkg::OP_BYTE, known_cmds[5'($urandom_range(0, 20))]);
        count++;
      end else if (kind < 9) begin
        push_cmd(dcd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        count++;
      end else begin
        push_cmd(dcd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        count++;
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = dcd_pkg::OP_BYTE;
    req_if.command_byte = 8'd0;
    rsp_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = 16'd0;
    m_speed   = dcd_pkg::SPEED_RESET;
    m_motion  = dcd_pkg::MOT_STOP;
    m_idle    = '0;
    m_front   = 1'b0;
    m_rear    = 1'b0;
    m_horn    = 1'b0;
    m_timeout = dcd_pkg::TIMEOUT_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: speeds under F, every motion, lights, horn, unknown bytes, tick
    @(negedge clk_i);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_F);
    for (int i = 0; i < 6; i++) push_cmd(dcd_pkg::OP_BYTE, known_cmds[i]);
    for (int i = 6; i < 15; i++) push_cmd(dcd_pkg::OP_BYTE, known_cmds[i]);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_0);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_H);
    for (int i = 15; i < 21; i += 2) push_cmd(dcd_pkg::OP_BYTE, known_cmds[i]);
    push_cmd(dcd_pkg::OP_BYTE, 8'h00);
    push_cmd(dcd_pkg::OP_BYTE, 8'hFF);
    push_cmd(dcd_pkg::OP_TICK, 8'hFF);
    for (int i = 16; i < 21; i += 2) push_cmd(dcd_pkg::OP_BYTE, known_cmds[i]);
    drain();

    // zero timeout: first tick after a byte stops
    set_failsafe_timeout(16'd0);
    @(negedge clk_i);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_9);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_F);
    push_cmd(dcd_pkg::OP_TICK, 8'h00);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_J);
    push_cmd(dcd_pkg::OP_TICK, 8'h00);
    drain();

    set_failsafe_timeout(16'd1);
    @(negedge clk_i);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_G);
    push_cmd(dcd_pkg::OP_TICK, 8'h00);
    push_cmd(dcd_pkg::OP_TICK, 8'h00);
    push_cmd(dcd_pkg::OP_TICK, 8'h00);
    drain();

    // full timeout: ticks never stop the motion, streamed with no idling
    set_failsafe_timeout(16'hFFFF);
    idle_off = 1'b1;
    @(negedge clk_i);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_R);
    repeat (20) push_cmd(dcd_pkg::OP_TICK, 8'h00);
    push_cmd(dcd_pkg::OP_BYTE, dcd_pkg::CHR_I);
    push_cmd(dcd_pkg::OP_TICK, 8'h00);
    drain();

    // random phases
    set_failsafe_timeout(16'($urandom_range(1, 8)));
    @(negedge clk_i);
    fill_random(85);
    drain();

    set_failsafe_timeout(16'($urandom_range(9, 40)));
    idle_off = 1'b0;
    @(negedge clk_i);
    fill_random(85);
    drain();

    set_failsafe_timeout(16'hFFFE);
    @(negedge clk_i);
    fill_random(85);
    stall_go = 1'b1;
    drain();

    set_failsafe_timeout(16'($urandom_range(1, 4)));
    @(negedge clk_i);
    fill_random(85);
    drain();

    repeat (4) @(posedge clk_i);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
